// ===== hdl/iara_pkg.sv =====
`default_nettype none

package iara_pkg;

	// item kinds carried on s_tuser
	typedef enum logic [1:0] {
		OP_LOAD = 2'd0,
		OP_ADD  = 2'd1,
		OP_READ = 2'd2,
		OP_NONE = 2'd3
	} op_t;

	// result status carried on m_tuser
	typedef enum logic [1:0] {
		ST_DONE    = 2'd0,
		ST_ROW_OOR = 2'd1,
		ST_COL_OOR = 2'd2,
		ST_RSVD    = 2'd3
	} status_t;

	localparam int OP_W      = 2;
	localparam int INDEX_W   = 32;
	localparam int COLUMN_W  = 7;
	localparam int VALUE_W   = 16;
	localparam int DATA_W    = 16;
	localparam int STATUS_W  = 2;
	localparam int S_TDATA_W = 56;
	localparam int M_TDATA_W = 16;

	localparam int ROW_COUNT_W  = 7;
	localparam int ROW_LENGTH_W = 8;
	localparam int CFG_IDX_W    = 1;
	localparam int CFG_DATA_W   = 8;

	localparam logic [CFG_IDX_W-1:0]    REG_ROW_COUNT    = 1'd0;
	localparam logic [CFG_IDX_W-1:0]    REG_ROW_LENGTH   = 1'd1;
	localparam logic [ROW_COUNT_W-1:0]  ROW_COUNT_RST    = 7'd64;
	localparam logic [ROW_LENGTH_W-1:0] ROW_LENGTH_RST   = 8'd128;

	// command strobes from the controller to the datapath
	typedef struct packed {
		logic capture;
		logic check;
		logic lookup;
		logic commit;
	} dp_cmd_t;

endpackage

`default_nettype wire

// ===== hdl/iara_ctrl.sv =====
`default_nettype none

module iara_ctrl
	import iara_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    s_tvalid,
	output logic         s_tready,
	output logic         m_tvalid,
	input  wire logic    m_tready,
	output dp_cmd_t      cmd
);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_CHECK  = 4'b0010,
		ST_LOOKUP = 4'b0100,
		ST_UPDATE = 4'b1000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   slot_free;

	assign s_tready  = (state_q == ST_IDLE);
	assign m_tvalid  = out_valid_q;
	assign slot_free = !out_valid_q || m_tready;

	always_comb begin
		cmd         = '0;
		cmd.capture = s_tvalid && (state_q == ST_IDLE);
		cmd.check   = (state_q == ST_CHECK);
		cmd.lookup  = (state_q == ST_LOOKUP);
		cmd.commit  = (state_q == ST_UPDATE) && slot_free;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) state_d = ST_CHECK;
			end
			ST_CHECK:  state_d = ST_LOOKUP;
			ST_LOOKUP: state_d = ST_UPDATE;
			ST_UPDATE: begin
				// hold until the output register is free
				if (slot_free) state_d = ST_IDLE;
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_commit_shows_word: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> m_tvalid)
		else $error("committed result not presented");

	a_accept_to_check: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> state_q == ST_CHECK)
		else $error("accepted word did not enter check");

	a_update_holds: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_UPDATE && !slot_free |=> state_q == ST_UPDATE && m_tvalid)
		else $error("update left while output stalled");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> !cmd.capture)
		else $error("capture while busy");

endmodule

`default_nettype wire

// ===== hdl/iara_dp.sv =====
`default_nettype none

module iara_dp
	import iara_pkg::*;
#(
	parameter int MAX_ROWS   = 64,
	parameter int MAX_COLS   = 128,
	parameter int ELEM_WIDTH = 16
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire dp_cmd_t                 cmd,
	input  wire logic                    cfg_we,
	input  wire logic [CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [CFG_DATA_W-1:0]   cfg_data,
	input  wire logic [OP_W-1:0]         in_op,
	input  wire logic [INDEX_W-1:0]      in_raw_index,
	input  wire logic [COLUMN_W-1:0]     in_column,
	input  wire logic [VALUE_W-1:0]      in_value,
	output logic      [DATA_W-1:0]       data,
	output logic      [STATUS_W-1:0]     status
);

	localparam int DEPTH  = MAX_ROWS * MAX_COLS;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int RIDX_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

	logic [ROW_COUNT_W-1:0]  row_count_q;
	logic [ROW_LENGTH_W-1:0] row_length_q;

	op_t                  op_q;
	logic [INDEX_W-1:0]   raw_q;
	logic [COLUMN_W-1:0]  col_q;
	logic [VALUE_W-1:0]   value_q;

	logic [RIDX_W-1:0]    row_q;
	status_t              chk_q;
	logic                 act_q;
	logic [ADDR_W-1:0]    addr_q;
	logic [ELEM_WIDTH-1:0] rd_q;
	logic [DATA_W-1:0]    data_q;
	status_t              status_q;

	logic [ELEM_WIDTH-1:0] accum_q [DEPTH];

	logic signed [INDEX_W:0] row_adj;
	logic [INDEX_W-1:0]      rows_lim;
	logic [ROW_LENGTH_W+6:0] cols_lim;
	logic                    row_ok;
	logic                    col_ok;
	logic [ADDR_W-1:0]       addr_next;
	logic [32:0]             value_wide;
	logic [ELEM_WIDTH-1:0]   value_ext;
	logic [ELEM_WIDTH-1:0]   new_elem;
	logic [32:0]             elem_wide;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q  <= ROW_COUNT_RST;
			row_length_q <= ROW_LENGTH_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ROW_COUNT:  row_count_q  <= cfg_data[ROW_COUNT_W-1:0];
				REG_ROW_LENGTH: row_length_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// negative add index counts back from the end of the table
	always_comb begin
		row_adj = $signed({raw_q[INDEX_W-1], raw_q});
		if (op_q == OP_ADD && raw_q[INDEX_W-1]) begin
			row_adj = row_adj + $signed({{(INDEX_W+1-ROW_COUNT_W){1'b0}}, row_count_q});
		end
	end

	assign rows_lim = (INDEX_W'(row_count_q) < INDEX_W'(MAX_ROWS)) ?
		INDEX_W'(row_count_q) : INDEX_W'(MAX_ROWS);
	assign cols_lim = ((ROW_LENGTH_W+7)'(row_length_q) < (ROW_LENGTH_W+7)'(MAX_COLS)) ?
		(ROW_LENGTH_W+7)'(row_length_q) : (ROW_LENGTH_W+7)'(MAX_COLS);
	assign row_ok = !row_adj[INDEX_W] && (row_adj[INDEX_W-1:0] < rows_lim);
	assign col_ok = (ROW_LENGTH_W+7)'(col_q) < cols_lim;

	assign addr_next = ADDR_W'(row_q) * ADDR_W'(MAX_COLS) + ADDR_W'(col_q);

	assign value_wide = {{17{value_q[VALUE_W-1]}}, value_q};
	assign value_ext  = value_wide[ELEM_WIDTH-1:0];

	always_comb begin
		case (op_q)
			OP_LOAD: new_elem = value_ext;
			OP_ADD:  new_elem = rd_q + value_ext;
			default: new_elem = rd_q;
		endcase
	end

	assign elem_wide = {{(33-ELEM_WIDTH){new_elem[ELEM_WIDTH-1]}}, new_elem};

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q    <= op_t'(in_op);
			raw_q   <= in_raw_index;
			col_q   <= in_column;
			value_q <= in_value;
		end
		if (cmd.check) begin
			row_q <= row_adj[RIDX_W-1:0];
			if (op_q == OP_NONE) begin
				chk_q <= ST_DONE;
				act_q <= 1'b0;
			end else if (!row_ok) begin
				chk_q <= ST_ROW_OOR;
				act_q <= 1'b0;
			end else if (!col_ok) begin
				chk_q <= ST_COL_OOR;
				act_q <= 1'b0;
			end else begin
				chk_q <= ST_DONE;
				act_q <= 1'b1;
			end
		end
		if (cmd.lookup) begin
			addr_q <= addr_next;
			rd_q   <= accum_q[addr_next];
		end
		if (cmd.commit) begin
			data_q   <= act_q ? elem_wide[DATA_W-1:0] : '0;
			status_q <= chk_q;
			if (act_q && op_q != OP_READ) begin
				accum_q[addr_q] <= new_elem;
			end
		end
	end

	assign data   = data_q;
	assign status = status_q;

endmodule

`default_nettype wire

// ===== hdl/index_add_row_accumulator_unit.sv =====
`default_nettype none

// Channel  Dir  Handshake               Payload
// s_       in   s_tvalid / s_tready     s_tdata: raw_index, column, value; s_tuser: op
// m_       out  m_tvalid / m_tready     m_tdata: data; m_tuser: status
// cfg_     in   cfg_valid / cfg_ready   cfg_index, cfg_data
//
// Each word passes through capture, range check, table read, then update
// and write back into the output register, in that order; the single-port
// table read-modify-write sets this sequence.
// The table is not cleared at reset; every entry must be loaded before use.
// The next word is taken while a result waits in the output register; a
// stalled m_ side holds the block in its update step.
// Configuration writes are always ready.

module index_add_row_accumulator_unit
	import iara_pkg::*;
#(
	parameter int MAX_ROWS   = 64,
	parameter int MAX_COLS   = 128,
	parameter int ELEM_WIDTH = 16
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	input  wire logic [S_TDATA_W-1:0]   s_tdata,   // raw_index[31:0], column[38:32], value[54:39]
	input  wire logic [OP_W-1:0]        s_tuser,   // op[1:0]
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	output logic      [M_TDATA_W-1:0]   m_tdata,   // data[15:0]
	output logic      [STATUS_W-1:0]    m_tuser,   // status[1:0]
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

	dp_cmd_t cmd;

	assign cfg_ready = 1'b1;

	iara_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	iara_dp #(
		.MAX_ROWS   (MAX_ROWS),
		.MAX_COLS   (MAX_COLS),
		.ELEM_WIDTH (ELEM_WIDTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_op        (s_tuser),
		.in_raw_index (s_tdata[31:0]),
		.in_column    (s_tdata[38:32]),
		.in_value     (s_tdata[54:39]),
		.data         (m_tdata),
		.status       (m_tuser)
	);

endmodule

`default_nettype wire

// ===== tb/iara_checker.sv =====
`timescale 1ns / 1ps

module iara_checker
	import iara_pkg::*;
#(
	parameter int MAX_ROWS = 64,
	parameter int MAX_COLS = 128
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	input  wire logic                  s_tready,
	input  wire logic [S_TDATA_W-1:0]  s_tdata,   // raw_index[31:0], column[38:32], value[54:39]
	input  wire logic [OP_W-1:0]       s_tuser,   // op[1:0]
	input  wire logic                  m_tvalid,
	input  wire logic                  m_tready,
	input  wire logic [M_TDATA_W-1:0]  m_tdata,   // data[15:0]
	input  wire logic [STATUS_W-1:0]   m_tuser,   // status[1:0]
	input  wire logic                  cfg_valid,
	input  wire logic                  cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output int                         fail_count,
	output int                         pending,
	output int                         results_seen
);

	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		logic [DATA_W-1:0] data;
		status_t           status;
	} entry_result_t;

	logic [DATA_W-1:0]       acc_mem [0:MAX_ROWS*MAX_COLS-1];
	logic [ROW_COUNT_W-1:0]  row_count_q;
	logic [ROW_LENGTH_W-1:0] row_length_q;
	entry_result_t           result_q [$];
	entry_result_t           want;

	// Update the shadow table for one word and return the result it must produce.
	function automatic entry_result_t apply_word(input op_t op,
			input logic signed [INDEX_W-1:0] idx, input logic [COLUMN_W-1:0] col,
			input logic [VALUE_W-1:0] val);
		entry_result_t r;
		longint        row;
		longint        rows;
		longint        cols;
		int            addr;
		r.data   = '0;
		r.status = ST_DONE;
		rows = (row_count_q < MAX_ROWS) ? row_count_q : MAX_ROWS;
		cols = (row_length_q < MAX_COLS) ? row_length_q : MAX_COLS;
		if (op == OP_NONE)
			return r;
		row = longint'(idx);
		// only adds count from the end, and the raw register value is added
		if (op == OP_ADD && row < 0)
			row += longint'(row_count_q);
		if (row < 0 || row >= rows) begin
			r.status = ST_ROW_OOR;
			return r;
		end
		if (col >= cols) begin
			r.status = ST_COL_OOR;
			return r;
		end
		addr = int'(row) * MAX_COLS + int'(col);
		case (op)
			OP_LOAD: acc_mem[addr] = val;
			OP_ADD:  acc_mem[addr] = acc_mem[addr] + val;
			default: ;
		endcase
		r.data = acc_mem[addr];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q  = ROW_COUNT_RST;
			row_length_q = ROW_LENGTH_RST;
			result_q.delete();
			fail_count   = 0;
			results_seen = 0;
			pending      = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_ROW_COUNT:  row_count_q  = cfg_data[ROW_COUNT_W-1:0];
					REG_ROW_LENGTH: row_length_q = cfg_data[ROW_LENGTH_W-1:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				result_q.push_back(apply_word(op_t'(s_tuser), s_tdata[INDEX_W-1:0],
					s_tdata[INDEX_W +: COLUMN_W], s_tdata[INDEX_W+COLUMN_W +: VALUE_W]));
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (result_q.size() == 0) begin
					fail_count++;
					if (fail_count <= MAX_REPORTS)
						$display("[%0t] unexpected result word: data %h status %0d",
							$realtime, m_tdata, m_tuser);
				end else begin
					want = result_q.pop_front();
					if (want.data !== m_tdata || want.status !== m_tuser) begin
						fail_count++;
						if (fail_count <= MAX_REPORTS)
							$display("[%0t] result %0d: expected data %h status %0d, got data %h status %0d",
								$realtime, results_seen, want.data, want.status, m_tdata, m_tuser);
					end
				end
			end
			pending = result_q.size();
		end
	end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
	import iara_pkg::*;

	localparam int TB_ROWS     = 64;
	localparam int TB_COLS     = 128;
	localparam int CYCLE_LIMIT = 200000;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [S_TDATA_W-1:0]  s_tdata;
	logic [OP_W-1:0]       s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [M_TDATA_W-1:0]  m_tdata;
	logic [STATUS_W-1:0]   m_tuser;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int fail_count;
	int pending;
	int results_seen;

	// stimulus-side view of the table shape and of entries holding a value
	logic [ROW_COUNT_W-1:0]  rc_cur;
	logic [ROW_LENGTH_W-1:0] rl_cur;
	bit                      loaded [0:TB_ROWS*TB_COLS-1];

	int  s_left, m_left;
	bit  s_calm, m_calm;
	int  m_gap;
	int  words_sent;
	int  settings_used;
	int  cycles;

	index_add_row_accumulator_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	iara_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tuser      (s_tuser),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tuser      (m_tuser),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.fail_count   (fail_count),
		.pending      (pending),
		.results_seen (results_seen)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
			$display("FAILURE");
			$finish;
		end
	end

	// Alternate calm stretches (no idling) with stretches of random gaps.
	function automatic int draw_gap(inout int left, inout bit calm);
		if (left == 0) begin
			left = $urandom_range(8, 40);
			calm = ($urandom_range(0, 2) == 0);
		end
		left--;
		return calm ? 0 : $urandom_range(0, 5);
	endfunction

	// Table address a word touches, or -1 when it is rejected or does nothing.
	function automatic int entry_addr(input op_t op, input logic [INDEX_W-1:0] idx,
			input logic [COLUMN_W-1:0] col);
		longint row;
		longint rows;
		longint cols;
		row  = longint'(signed'(idx));
		rows = (rc_cur < TB_ROWS) ? rc_cur : TB_ROWS;
		cols = (rl_cur < TB_COLS) ? rl_cur : TB_COLS;
		if (op == OP_NONE)
			return -1;
		if (op == OP_ADD && row < 0)
			row += longint'(rc_cur);
		if (row < 0 || row >= rows || col >= cols)
			return -1;
		return int'(row) * TB_COLS + int'(col);
	endfunction

	// Entered and left at a falling edge; valid stays high into the next word.
	task automatic send_word(input op_t op, input logic [INDEX_W-1:0] idx,
			input logic [COLUMN_W-1:0] col, input logic [VALUE_W-1:0] val);
		int gap;
		int addr;
		gap  = draw_gap(s_left, s_calm);
		addr = entry_addr(op, idx, col);
		if (addr >= 0 && op == OP_LOAD)
			loaded[addr] = 1'b1;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tdata  <= {1'b0, val, col, idx};
		s_tuser  <= op;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		words_sent++;
	endtask

	// Drop valid, wait for every result, then let the pipeline drain.
	task automatic settle();
		s_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic set_table_shape(input logic [CFG_DATA_W-1:0] rc_data,
			input logic [CFG_DATA_W-1:0] rl_data);
		settle();
		cfg_index <= REG_ROW_COUNT;
		cfg_data  <= rc_data;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_index <= REG_ROW_LENGTH;
		cfg_data  <= rl_data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		rc_cur = rc_data[ROW_COUNT_W-1:0];
		rl_cur = rl_data[ROW_LENGTH_W-1:0];
		settings_used++;
	endtask

	task automatic run_random_phase(input int n_words);
		op_t                 op;
		logic [INDEX_W-1:0]  idx;
		logic [COLUMN_W-1:0] col;
		logic [VALUE_W-1:0]  val;
		int                  rows;
		int                  cols;
		int                  row;
		int                  pick;
		int                  addr;
		rows = (rc_cur < TB_ROWS) ? rc_cur : TB_ROWS;
		cols = (rl_cur < TB_COLS) ? rl_cur : TB_COLS;
		for (int i = 0; i < n_words; i++) begin
			op = ($urandom_range(0, 99) < 3) ? OP_NONE : op_t'($urandom_range(0, 2));

			pick = $urandom_range(0, 99);
			if (rows == 0 || pick >= 85) begin
				idx = $urandom();
			end else if (pick >= 75) begin
				case ($urandom_range(0, 4))
					0: idx = rows;
					1: idx = 32'hFFFF_FFFF;
					2: idx = 32'h8000_0000;
					3: idx = 32'h7FFF_FFFF;
					default: idx = -int'(rc_cur) - 1;
				endcase
			end else begin
				// a small hot set keeps back-to-back words on the same entries
				row = (pick < 40) ? $urandom_range(0, (rows - 1 < 3) ? rows - 1 : 3)
				                  : $urandom_range(0, rows - 1);
				idx = (op == OP_ADD && $urandom_range(0, 2) == 0) ? row - int'(rc_cur) : row;
			end

			pick = $urandom_range(0, 99);
			if (cols == 0 || pick >= 88)
				col = COLUMN_W'($urandom());
			else if (pick < 40)
				col = COLUMN_W'($urandom_range(0, (cols - 1 < 3) ? cols - 1 : 3));
			else
				col = COLUMN_W'($urandom_range(0, cols - 1));

			case ($urandom_range(0, 19))
				0: val = 16'h7FFF;
				1: val = 16'h8000;
				2: val = 16'hFFFF;
				3: val = 16'h0000;
				default: val = VALUE_W'($urandom());
			endcase

			// never touch an entry that holds no value yet
			addr = entry_addr(op, idx, col);
			if (addr >= 0 && (op == OP_ADD || op == OP_READ) && !loaded[addr])
				op = OP_LOAD;
			send_word(op, idx, col, val);
		end
	endtask

	initial begin
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			m_gap = draw_gap(m_left, m_calm);
			if (m_gap > 0) begin
				m_tready <= 1'b0;
				repeat (m_gap) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			@(negedge clk);
		end
	end

	initial begin
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = OP_LOAD;
		cfg_valid = 1'b0;
		cfg_index = REG_ROW_COUNT;
		cfg_data  = '0;
		rc_cur    = ROW_COUNT_RST;
		rl_cur    = ROW_LENGTH_RST;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		set_table_shape(8'd64, 8'd128);
		send_word(OP_LOAD, 32'd0, 7'd0, 16'h7FFF);
		send_word(OP_ADD, 32'd0, 7'd0, 16'h0001);          // wraps to most negative
		send_word(OP_READ, 32'd0, 7'd0, 16'h0000);
		send_word(OP_LOAD, 32'd63, 7'd127, 16'h8000);
		send_word(OP_ADD, 32'hFFFF_FFFF, 7'd127, 16'hFFFF); // last row from the end
		send_word(OP_READ, 32'd63, 7'd127, 16'h0000);
		send_word(OP_LOAD, 32'd0, 7'd10, 16'h1234);
		send_word(OP_ADD, 32'hFFFF_FFC0, 7'd10, 16'h0100);  // -64 lands on row 0
		send_word(OP_READ, 32'hFFFF_FFC0, 7'd10, 16'h0000); // negative read is rejected
		send_word(OP_LOAD, 32'hFFFF_FFFF, 7'd5, 16'h5555);
		send_word(OP_ADD, 32'hFFFF_FFBF, 7'd0, 16'h0001);   // still negative after wrap
		send_word(OP_ADD, 32'd64, 7'd0, 16'h0001);
		send_word(OP_LOAD, 32'h7FFF_FFFF, 7'd0, 16'h0001);
		send_word(OP_ADD, 32'h8000_0000, 7'd0, 16'h0001);
		send_word(OP_READ, 32'h8000_0000, 7'd0, 16'h0000);
		send_word(OP_NONE, 32'd0, 7'd0, 16'hFFFF);
		send_word(OP_READ, 32'd0, 7'd10, 16'h0000);

		set_table_shape(8'd64, 8'd100);
		send_word(OP_LOAD, 32'd2, 7'd99, 16'h8001);
		send_word(OP_READ, 32'd2, 7'd100, 16'h0000);
		send_word(OP_ADD, 32'd2, 7'd127, 16'h0001);
		send_word(OP_READ, 32'd70, 7'd120, 16'h0000);       // row rejected ahead of column
		send_word(OP_ADD, 32'd2, 7'd99, 16'h8000);

		set_table_shape(8'd1, 8'd1);
		run_random_phase(60);
		set_table_shape(8'd64, 8'd128);
		run_random_phase(250);
		set_table_shape(8'd0, 8'd128);
		run_random_phase(40);
		set_table_shape(8'd127, 8'd255);
		run_random_phase(150);
		set_table_shape(8'hE4, 8'd64);                      // top bit dropped: 100 rows
		run_random_phase(150);
		set_table_shape(8'd16, 8'd0);
		run_random_phase(40);
		set_table_shape(8'd40, 8'd37);
		run_random_phase(200);
		set_table_shape(8'd64, 8'd1);
		run_random_phase(80);
		set_table_shape(8'd64, 8'd128);
		run_random_phase(230);
		settle();

		$display("Sent %0d words over %0d table shapes; %0d results compared.",
			words_sent, settings_used, results_seen);
		$display("Loads, wrapping adds, reads, negative indices, row/column rejects, unused op.");
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/iara_pkg.sv
hdl/iara_ctrl.sv
hdl/iara_dp.sv
hdl/index_add_row_accumulator_unit.sv
tb/iara_checker.sv
tb/tb_top.sv
